// File: sv/tcpq_pkg.sv
`default_nettype none

package tcpq_pkg;

    localparam int CLASS_DEPTH_DEF = 64;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int ADDR_BITS       = 3;

    typedef enum logic [2:0] {
        ST_PUSHED      = 3'd0,
        ST_PUSHED_DROP = 3'd1,
        ST_REJECTED    = 3'd2,
        ST_POPPED      = 3'd3,
        ST_EMPTY       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CLS_LOW    = 2'd0,
        CLS_NORMAL = 2'd1,
        CLS_HIGH   = 2'd2,
        CLS_UNUSED = 2'd3
    } class_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic {
        REG_MAX_TOTAL = 1'b0,
        REG_NONE      = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic        operation;
        logic [1:0]  priority_req;
        logic [31:0] payload;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] item_out;
        logic [1:0]  item_class;
        logic [7:0]  total_count;
    } out_t;

endpackage

`default_nettype wire

// File: sv/tcpq_ram.sv
`default_nettype none

module tcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/three_class_priority_queue_pushout.sv
// Output: the result of an accepted transaction is registered in the output register.
// Throughput: one push or pop per cycle unless out_ready stalls; each class RAM reads
// its head address every cycle, with a bypass for a handle appended to an empty class.
// Reset: asynchronous active low; clears head pointers, counts, total, max_total and
// the output valid. RAM contents are not cleared and are only read once written.
`default_nettype none

module three_class_priority_queue_pushout #(
    parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF,
    parameter int HANDLE_BITS = tcpq_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire tcpq_pkg::in_t                  in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output tcpq_pkg::out_t                      out_item,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcpq_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    localparam int PW   = $clog2(CLASS_DEPTH);
    localparam int CW   = $clog2(CLASS_DEPTH + 1);
    localparam int TW   = $clog2(3 * CLASS_DEPTH + 1);
    localparam int CMPW = (TW > 8) ? TW : 8;
    localparam int SW   = CW + 1;

    logic [PW-1:0]          head_reg  [3];
    logic [PW-1:0]          head_next [3];
    logic [CW-1:0]          count_reg [3];
    logic [CW-1:0]          count_next[3];
    logic [PW-1:0]          tail      [3];
    logic [2:0]             byp_hit_reg;
    logic [2:0]             byp_hit_next;
    logic [HANDLE_BITS-1:0] byp_data_reg;
    logic [HANDLE_BITS-1:0] rd_data   [3];
    logic [HANDLE_BITS-1:0] head_data [3];
    logic [TW-1:0]          total_reg;
    logic [TW-1:0]          total_next;
    logic [7:0]             max_total_reg;
    logic                   out_valid_reg;
    tcpq_pkg::out_t         out_item_reg;
    tcpq_pkg::out_t         result;

    logic                   accept;
    logic [2:0]             take;
    logic [2:0]             app;
    logic [2:0]             nonempty;
    logic [2:0]             full;
    logic                   cls_full;
    logic                   limit_hit;
    logic [1:0]             take_cls;
    logic [HANDLE_BITS-1:0] handle;
    logic [HANDLE_BITS-1:0] item;
    logic [63:0]            pay_wide;
    logic [63:0]            item_wide;
    logic [CMPW-1:0]        total_wide;
    logic [CMPW-1:0]        max_wide;
    tcpq_pkg::status_t      status;

    assign pready    = 1'b1;
    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        prdata = '0;
        if (paddr[tcpq_pkg::ADDR_BITS-1] == tcpq_pkg::REG_MAX_TOTAL)
        begin
            prdata = {24'd0, max_total_reg};
        end
    end

    always_comb
    begin
        pay_wide = {32'd0, in_item.payload};
        handle   = pay_wide[HANDLE_BITS-1:0];
    end

    always_comb
    begin
        logic [SW-1:0] sum;
        for (int c = 0; c < 3; c++)
        begin
            nonempty[c]  = (count_reg[c] != '0);
            full[c]      = (count_reg[c] == CW'(CLASS_DEPTH));
            head_data[c] = byp_hit_reg[c] ? byp_data_reg : rd_data[c];
            sum = SW'(head_reg[c]) + SW'(count_reg[c]);
            if (sum >= SW'(CLASS_DEPTH))
            begin
                sum = sum - SW'(CLASS_DEPTH);
            end
            tail[c] = sum[PW-1:0];
        end
    end

    always_comb
    begin
        unique case (in_item.priority_req)
            tcpq_pkg::CLS_LOW:    cls_full = full[0];
            tcpq_pkg::CLS_NORMAL: cls_full = full[1];
            tcpq_pkg::CLS_HIGH:   cls_full = full[2];
            default:              cls_full = 1'b1;
        endcase
    end

    assign total_wide = CMPW'(total_reg);
    assign max_wide   = CMPW'(max_total_reg);
    assign limit_hit  = (max_total_reg != 8'd0) && (total_wide >= max_wide);

    always_comb
    begin
        take     = '0;
        app      = '0;
        take_cls = tcpq_pkg::CLS_LOW;
        status   = tcpq_pkg::ST_REJECTED;
        if (in_item.operation == tcpq_pkg::OP_POP)
        begin
            status = tcpq_pkg::ST_POPPED;
            priority if (nonempty[2])
            begin
                take[2]  = 1'b1;
                take_cls = tcpq_pkg::CLS_HIGH;
            end
            else if (nonempty[1])
            begin
                take[1]  = 1'b1;
                take_cls = tcpq_pkg::CLS_NORMAL;
            end
            else if (nonempty[0])
            begin
                take[0]  = 1'b1;
                take_cls = tcpq_pkg::CLS_LOW;
            end
            else
            begin
                status = tcpq_pkg::ST_EMPTY;
            end
        end
        else if (cls_full)
        begin
            status = tcpq_pkg::ST_REJECTED;
        end
        else if (limit_hit)
        begin
            priority if (in_item.priority_req != tcpq_pkg::CLS_LOW && nonempty[0])
            begin
                take[0]  = 1'b1;
                take_cls = tcpq_pkg::CLS_LOW;
                status   = tcpq_pkg::ST_PUSHED_DROP;
            end
            else if (in_item.priority_req == tcpq_pkg::CLS_HIGH && nonempty[1])
            begin
                take[1]  = 1'b1;
                take_cls = tcpq_pkg::CLS_NORMAL;
                status   = tcpq_pkg::ST_PUSHED_DROP;
            end
            else
            begin
                status = tcpq_pkg::ST_REJECTED;
            end
            if (status == tcpq_pkg::ST_PUSHED_DROP)
            begin
                app[in_item.priority_req] = 1'b1;
            end
        end
        else
        begin
            app[in_item.priority_req] = 1'b1;
            status = tcpq_pkg::ST_PUSHED;
        end
        if (!accept)
        begin
            take = '0;
            app  = '0;
        end
    end

    always_comb
    begin
        unique case (take_cls)
            tcpq_pkg::CLS_LOW:    item = head_data[0];
            tcpq_pkg::CLS_NORMAL: item = head_data[1];
            tcpq_pkg::CLS_HIGH:   item = head_data[2];
            default:              item = '0;
        endcase
        item_wide = '0;
        item_wide[HANDLE_BITS-1:0] = item;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            head_next[c] = head_reg[c];
            if (take[c])
            begin
                head_next[c] = (head_reg[c] == PW'(CLASS_DEPTH - 1)) ? '0 : head_reg[c] + 1'b1;
            end
            count_next[c]   = count_reg[c] + CW'(app[c]) - CW'(take[c]);
            byp_hit_next[c] = app[c] && (tail[c] == head_next[c]);
        end
        total_next = total_reg + TW'(app != '0) - TW'(take != '0);
    end

    always_comb
    begin
        logic [CMPW-1:0] tot;
        tot                = CMPW'(total_next);
        result.status      = status;
        result.item_out    = '0;
        result.item_class  = '0;
        result.total_count = tot[7:0];
        if (status == tcpq_pkg::ST_POPPED || status == tcpq_pkg::ST_PUSHED_DROP)
        begin
            result.item_out   = item_wide[31:0];
            result.item_class = take_cls;
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_class
        tcpq_ram #(
            .WIDTH (HANDLE_BITS),
            .DEPTH (CLASS_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (app[g]),
            .waddr (tail[g]),
            .wdata (handle),
            .raddr (head_next[g]),
            .rdata (rd_data[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
            byp_hit_reg   <= '0;
            total_reg     <= '0;
            max_total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                head_reg[c]  <= head_next[c];
                count_reg[c] <= count_next[c];
            end
            byp_hit_reg <= byp_hit_next;
            total_reg   <= total_next;
            if (psel && penable && pwrite &&
                paddr[tcpq_pkg::ADDR_BITS-1] == tcpq_pkg::REG_MAX_TOTAL)
            begin
                max_total_reg <= pwdata[7:0];
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (app != '0)
        begin
            byp_data_reg <= handle;
        end
        if (accept)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
module tb_top;

    localparam int DEPTH = tcpq_pkg::CLASS_DEPTH_DEF;

    typedef struct packed {
        logic           cfg;
        tcpq_pkg::in_t  stim;
        logic           typed;
        tcpq_pkg::out_t want;
    } dir_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    tcpq_pkg::in_t                  in_item;
    logic                           out_valid;
    logic                           out_ready;
    tcpq_pkg::out_t                 out_item;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tcpq_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    logic [31:0]     held [3][$];
    logic [7:0]      limit = '0;
    tcpq_pkg::out_t  owed [$];
    tcpq_pkg::out_t  want_r;
    int unsigned     faults = 0;
    int unsigned     replies_seen = 0;
    bit              calm = 1'b0;
    bit              stalled = 1'b0;

    // configuration rows carry the new limit in the payload
    dir_row_t plan [0:24] = '{
        '{1'b1, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_LOW, 32'd2}, 1'b0, '0},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_HIGH, 32'hFFFF_FFFF}, 1'b1,
          '{tcpq_pkg::ST_EMPTY, 32'h0, tcpq_pkg::CLS_LOW, 8'd0}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_UNUSED, 32'hFFFF_FFFF}, 1'b1,
          '{tcpq_pkg::ST_REJECTED, 32'h0, tcpq_pkg::CLS_LOW, 8'd0}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_LOW, 32'h0000_0000}, 1'b1,
          '{tcpq_pkg::ST_PUSHED, 32'h0, tcpq_pkg::CLS_LOW, 8'd1}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_LOW, 32'hFFFF_FFFF}, 1'b1,
          '{tcpq_pkg::ST_PUSHED, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_LOW, 32'h1234_5678}, 1'b1,
          '{tcpq_pkg::ST_REJECTED, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_NORMAL, 32'hA5A5_A5A5}, 1'b1,
          '{tcpq_pkg::ST_PUSHED_DROP, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_HIGH, 32'h5A5A_5A5A}, 1'b1,
          '{tcpq_pkg::ST_PUSHED_DROP, 32'hFFFF_FFFF, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_HIGH, 32'h0000_0001}, 1'b1,
          '{tcpq_pkg::ST_PUSHED_DROP, 32'hA5A5_A5A5, tcpq_pkg::CLS_NORMAL, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_HIGH, 32'h8000_0000}, 1'b1,
          '{tcpq_pkg::ST_REJECTED, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_NORMAL, 32'h7FFF_FFFF}, 1'b1,
          '{tcpq_pkg::ST_REJECTED, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_UNUSED, 32'h0000_0000}, 1'b1,
          '{tcpq_pkg::ST_REJECTED, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_LOW, 32'h0}, 1'b1,
          '{tcpq_pkg::ST_POPPED, 32'h5A5A_5A5A, tcpq_pkg::CLS_HIGH, 8'd1}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_LOW, 32'hDEAD_BEEF}, 1'b1,
          '{tcpq_pkg::ST_PUSHED, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_UNUSED, 32'h0000_1234}, 1'b1,
          '{tcpq_pkg::ST_POPPED, 32'h0000_0001, tcpq_pkg::CLS_HIGH, 8'd1}},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_NORMAL, 32'h0}, 1'b1,
          '{tcpq_pkg::ST_POPPED, 32'hDEAD_BEEF, tcpq_pkg::CLS_LOW, 8'd0}},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_LOW, 32'h0}, 1'b1,
          '{tcpq_pkg::ST_EMPTY, 32'h0, tcpq_pkg::CLS_LOW, 8'd0}},
        '{1'b1, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_LOW, 32'd0}, 1'b0, '0},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_NORMAL, 32'h3C3C_3C3C}, 1'b1,
          '{tcpq_pkg::ST_PUSHED, 32'h0, tcpq_pkg::CLS_LOW, 8'd1}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_HIGH, 32'hC3C3_C3C3}, 1'b1,
          '{tcpq_pkg::ST_PUSHED, 32'h0, tcpq_pkg::CLS_LOW, 8'd2}},
        '{1'b0, '{tcpq_pkg::OP_PUSH, tcpq_pkg::CLS_LOW, 32'h0F0F_0F0F}, 1'b1,
          '{tcpq_pkg::ST_PUSHED, 32'h0, tcpq_pkg::CLS_LOW, 8'd3}},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_LOW, 32'h0}, 1'b0, '0},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_LOW, 32'h0}, 1'b0, '0},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_LOW, 32'h0}, 1'b0, '0},
        '{1'b0, '{tcpq_pkg::OP_POP, tcpq_pkg::CLS_HIGH, 32'h0}, 1'b1,
          '{tcpq_pkg::ST_EMPTY, 32'h0, tcpq_pkg::CLS_LOW, 8'd0}}
    };

    three_class_priority_queue_pushout uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    function automatic tcpq_pkg::out_t queue_step(input tcpq_pkg::in_t x);
        tcpq_pkg::out_t r;
        int             c;
        int             victim;
        r = '0;
        if (x.operation == tcpq_pkg::OP_POP)
        begin
            r.status = tcpq_pkg::ST_EMPTY;
            for (c = 2; c >= 0; c--)
            begin
                if (held[c].size() != 0)
                begin
                    r.item_out   = held[c].pop_front();
                    r.item_class = c[1:0];
                    r.status     = tcpq_pkg::ST_POPPED;
                    break;
                end
            end
        end
        else if (x.priority_req == tcpq_pkg::CLS_UNUSED ||
                 held[x.priority_req].size() >= DEPTH)
        begin
            r.status = tcpq_pkg::ST_REJECTED;
        end
        else if (limit != 0 &&
                 held[0].size() + held[1].size() + held[2].size() >= int'(limit))
        begin
            victim = -1;
            if (x.priority_req != tcpq_pkg::CLS_LOW && held[tcpq_pkg::CLS_LOW].size() != 0)
                victim = tcpq_pkg::CLS_LOW;
            else if (x.priority_req == tcpq_pkg::CLS_HIGH &&
                     held[tcpq_pkg::CLS_NORMAL].size() != 0)
                victim = tcpq_pkg::CLS_NORMAL;
            if (victim < 0)
            begin
                r.status = tcpq_pkg::ST_REJECTED;
            end
            else
            begin
                r.item_out   = held[victim].pop_front();
                r.item_class = victim[1:0];
                held[x.priority_req].push_back(x.payload);
                r.status     = tcpq_pkg::ST_PUSHED_DROP;
            end
        end
        else
        begin
            held[x.priority_req].push_back(x.payload);
            r.status = tcpq_pkg::ST_PUSHED;
        end
        r.total_count = 8'(held[0].size() + held[1].size() + held[2].size());
        return r;
    endfunction

    task automatic offer(input tcpq_pkg::in_t x, input logic typed,
                         input tcpq_pkg::out_t want);
        tcpq_pkg::out_t predicted;
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= x;
        do @(posedge clk); while (!(in_valid && in_ready));
        predicted = queue_step(x);
        owed.push_back(typed ? want : predicted);
    endtask

    task automatic set_limit(input logic [7:0] v);
        in_valid <= 1'b0;
        while (owed.size() != 0) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tcpq_pkg::ADDR_BITS'(4 * tcpq_pkg::REG_MAX_TOTAL);
        pwdata  <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit = v;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!stalled && replies_seen >= 600 && in_valid)
            begin
                // hold off long enough for the queue to back up into the input
                stalled = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                out_ready <= calm || $urandom_range(0, 99) >= 19;
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            replies_seen++;
            if (owed.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected transaction: status %0d item %h class %0d total %0d",
                             out_item.status, out_item.item_out, out_item.item_class,
                             out_item.total_count);
            end
            else
            begin
                want_r = owed.pop_front();
                if (out_item.status !== want_r.status || out_item.item_out !== want_r.item_out
                    || out_item.item_class !== want_r.item_class
                    || out_item.total_count !== want_r.total_count)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("transaction %0d: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                 replies_seen, want_r.status, want_r.item_out,
                                 want_r.item_class, want_r.total_count, out_item.status,
                                 out_item.item_out, out_item.item_class,
                                 out_item.total_count);
                end
            end
        end
    end

    initial
    begin
        int             i;
        int             p;
        int             n;
        int unsigned    r;
        int unsigned    burst;
        int unsigned    mode;
        int unsigned    fav;
        int unsigned    push_pct;
        tcpq_pkg::in_t  x;
        int unsigned    caps [0:5];

        caps = '{0, 192, 1, 100, 70, 3};
        burst = 0;
        mode = 0;
        fav = 0;
        rst_n   = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 25; i++)
        begin
            if (plan[i].cfg)
                set_limit(plan[i].stim.payload[7:0]);
            else
                offer(plan[i].stim, plan[i].typed, plan[i].want);
        end

        for (p = 0; p < 8; p++)
        begin
            set_limit(p < 6 ? 8'(caps[p]) : 8'($urandom_range(0, 192)));
            calm = (p == 1);
            for (n = 0; n < 220; n++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(20, 120);
                    mode  = $urandom_range(0, 2);
                    fav   = $urandom_range(0, 2);
                end
                burst--;
                push_pct = (mode == 0) ? 85 : (mode == 1) ? 30 : 55;
                x.operation = ($urandom_range(0, 99) < push_pct) ?
                              tcpq_pkg::OP_PUSH : tcpq_pkg::OP_POP;
                r = $urandom_range(0, 99);
                if (r < 5)
                    x.priority_req = tcpq_pkg::CLS_UNUSED;
                else if (r < 65)
                    x.priority_req = fav[1:0];
                else
                    x.priority_req = 2'($urandom_range(0, 2));
                r = $urandom_range(0, 15);
                x.payload = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
                offer(x, 1'b0, '0);
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        while (owed.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        faults += owed.size();
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
